FILE: hw/rtl/tcc_pkg.sv
package tcc_pkg;

  localparam int unsigned CordicIterDefault = 16;
  localparam int unsigned AtanEntries       = 24;

  // datapath widths
  localparam int unsigned XW     = 34;  // CORDIC vector
  localparam int unsigned CW     = 27;  // companion field pair
  localparam int unsigned ZW     = 24;  // angle, 1/16384 degree
  localparam int unsigned GainW  = 25;
  localparam int unsigned GainSh = 24;
  localparam int unsigned TW     = 28;  // field after hard-iron removal
  localparam int unsigned PW     = 44;  // soft-iron product
  localparam int unsigned SoftSh = 14;
  localparam int unsigned AngSh  = 8;

  localparam logic signed [XW-1:0]    ZeroLen  = XW'(64'sd1 <<< 30);
  localparam logic signed [ZW-1:0]    HalfTurn = ZW'(2949120);
  localparam logic signed [GainW-1:0] GainInv  = GainW'(10188014);
  localparam logic signed [15:0]      LimFull  = 16'sd11520;
  localparam logic signed [15:0]      LimHalf  = 16'sd5760;

  typedef enum logic [2:0] {
    CfgHardX  = 3'd0,
    CfgHardY  = 3'd1,
    CfgSoftXx = 3'd2,
    CfgSoftXy = 3'd3,
    CfgSoftYx = 3'd4,
    CfgSoftYy = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] mx;
    logic               deg;
  } roll_side_t;

  typedef struct packed {
    logic signed [CW-1:0] pyc;
    logic signed [ZW-1:0] zr;
    logic                 deg;
  } pitch_side_t;

  typedef struct packed {
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] zp;
    logic                 deg;
  } yaw_side_t;

  // atan(2^-i) in 1/16384 degree, rounded
  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0:  r = ZW'(737280);
      1:  r = ZW'(435242);
      2:  r = ZW'(229970);
      3:  r = ZW'(116736);
      4:  r = ZW'(58595);
      5:  r = ZW'(29326);
      6:  r = ZW'(14667);
      7:  r = ZW'(7334);
      8:  r = ZW'(3667);
      9:  r = ZW'(1833);
      10: r = ZW'(917);
      11: r = ZW'(458);
      12: r = ZW'(229);
      13: r = ZW'(115);
      14: r = ZW'(57);
      15: r = ZW'(29);
      16: r = ZW'(14);
      17: r = ZW'(7);
      18: r = ZW'(4);
      19: r = ZW'(2);
      20: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half up by 2^8, then saturate to +-lim
  function automatic logic signed [15:0] ang_out(input logic signed [ZW:0] z,
                                                 input logic signed [15:0] lim);
    logic signed [ZW:0] r;
    r = (z + (ZW+1)'(128)) >>> AngSh;
    if (r > lim) begin
      r = (ZW+1)'(lim);
    end else if (r < -lim) begin
      r = -(ZW+1)'(lim);
    end
    return 16'(r);
  endfunction

endpackage

FILE: hw/rtl/tcc_cordic.sv
module tcc_cordic #(
  parameter int unsigned Iter  = tcc_pkg::CordicIterDefault,
  parameter int unsigned SideW = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [tcc_pkg::XW-1:0]  x_i,
  input  logic signed [tcc_pkg::XW-1:0]  y_i,
  input  logic signed [tcc_pkg::CW-1:0]  p_i,
  input  logic signed [tcc_pkg::CW-1:0]  q_i,
  input  logic        [SideW-1:0]        side_i,
  output logic                           valid_o,
  output logic signed [tcc_pkg::XW-1:0]  len_o,
  output logic signed [tcc_pkg::ZW-1:0]  z_o,
  output logic signed [tcc_pkg::CW-1:0]  p_o,
  output logic signed [tcc_pkg::CW-1:0]  q_o,
  output logic        [SideW-1:0]        side_o
);
  import tcc_pkg::*;

  logic        [Iter:0]   v_q;
  logic signed [XW-1:0]   x_q    [Iter+1];
  logic signed [XW-1:0]   y_q    [Iter+1];
  logic signed [CW-1:0]   p_q    [Iter+1];
  logic signed [CW-1:0]   q_q    [Iter+1];
  logic signed [ZW-1:0]   z_q    [Iter+1];
  logic        [SideW-1:0] side_q [Iter+1];

  logic signed [XW-1:0] x0, y0;
  logic signed [CW-1:0] p0, q0;
  logic signed [ZW-1:0] z0;

  // zero vector becomes +x axis; left half plane is folded by 180 deg
  always_comb begin
    x0 = x_i;
    y0 = y_i;
    p0 = p_i;
    q0 = q_i;
    z0 = '0;
    if (x_i == '0 && y_i == '0) begin
      x0 = ZeroLen;
    end
    if (x0 < 0) begin
      z0 = y_i[XW-1] ? -HalfTurn : HalfTurn;
      x0 = -x0;
      y0 = -y0;
      p0 = -p0;
      q0 = -q0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      p_q[0]    <= p0;
      q_q[0]    <= q0;
      z_q[0]    <= z0;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < Iter; i++) begin : g_step
    logic signed [XW-1:0] xs, ys;
    logic signed [CW-1:0] ps, qs;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign ps = p_q[i] >>> i;
    assign qs = q_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          p_q[i+1] <= p_q[i] + qs;
          q_q[i+1] <= q_q[i] - ps;
          z_q[i+1] <= z_q[i] + atan_tab(i);
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          p_q[i+1] <= p_q[i] - qs;
          q_q[i+1] <= q_q[i] + ps;
          z_q[i+1] <= z_q[i] - atan_tab(i);
        end
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[Iter];
  assign len_o   = x_q[Iter];
  assign z_o     = z_q[Iter];
  assign p_o     = p_q[Iter];
  assign q_o     = q_q[Iter];
  assign side_o  = side_q[Iter];

endmodule

FILE: hw/rtl/tilt_compensated_compass.sv
// Tilt-compensated compass: one accel/mag sample in, roll, pitch and heading out.
// Input stream: s_axis word carries accel x/y/z and mag x/y/z, 16 bit each.
// Output stream: m_axis word carries roll, pitch and yaw in 1/64 degree;
// tuser flags a zero acceleration vector, in which case all angles are zero.
// Calibration (hard-iron bias, soft-iron matrix) is written through cfg_*;
// the user must write it only while no sample is in flight, which the block
// does not enforce; the values take effect for the next sample. Three pipelined
// CORDIC vectoring units (roll, pitch, heading) of N = CORDIC_ITERATIONS stages
// each (N capped at AtanEntries), plus gain and calibration stages, form the
// pipeline. Throughput is one word per cycle while the skid register is empty;
// every stage has its own valid bit. When the receiver stalls, the output
// register holds and one further word lands in a skid register; only then
// does s_axis_tready fall, and the whole pipeline freezes until the skid
// drains. Nothing is dropped or repeated. Reset clears all valid bits and
// loads identity calibration: zero bias, unit soft-iron diagonal.
module tilt_compensated_compass #(
  parameter int unsigned CORDIC_ITERATIONS = tcc_pkg::CordicIterDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // roll_deg, pitch_deg, yaw_deg, 4 bits zero
  output logic [47:0] m_axis_tdata,
  // degenerate
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import tcc_pkg::*;

  localparam int unsigned Iter = (CORDIC_ITERATIONS > AtanEntries) ? AtanEntries
                                                                    : CORDIC_ITERATIONS;
  localparam int unsigned GW  = CW + GainW;
  localparam int unsigned GLW = 32 + GainW;

  logic en;
  logic skid_valid_q, out_valid_q;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // calibration registers
  logic signed [15:0] hard_x_q, hard_y_q, soft_xx_q, soft_xy_q, soft_yx_q, soft_yy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_x_q  <= '0;
      hard_y_q  <= '0;
      soft_xx_q <= 16'sd16384;
      soft_xy_q <= '0;
      soft_yx_q <= '0;
      soft_yy_q <= 16'sd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHardX:  hard_x_q  <= cfg_data_i;
        CfgHardY:  hard_y_q  <= cfg_data_i;
        CfgSoftXx: soft_xx_q <= cfg_data_i;
        CfgSoftXy: soft_xy_q <= cfg_data_i;
        CfgSoftYx: soft_yx_q <= cfg_data_i;
        CfgSoftYy: soft_yy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  logic s1_valid_q;
  logic signed [15:0] s1_ax_q, s1_ay_q, s1_az_q, s1_mx_q, s1_my_q, s1_mz_q;
  logic s1_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ax_q  <= s_axis_tdata[15:0];
      s1_ay_q  <= s_axis_tdata[31:16];
      s1_az_q  <= s_axis_tdata[47:32];
      s1_mx_q  <= s_axis_tdata[63:48];
      s1_my_q  <= s_axis_tdata[79:64];
      s1_mz_q  <= s_axis_tdata[95:80];
      s1_deg_q <= (s_axis_tdata[47:0] == '0);
    end
  end

  // roll: vector (-az, -ay), level (mz, my)
  roll_side_t           r_side_in, r_side;
  logic                 r_valid;
  logic signed [XW-1:0] r_len;
  logic signed [ZW-1:0] r_z;
  logic signed [CW-1:0] r_a, r_b;

  assign r_side_in = '{ax: s1_ax_q, mx: s1_mx_q, deg: s1_deg_q};

  tcc_cordic #(.Iter(Iter), .SideW($bits(roll_side_t))) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .x_i     (-(XW'(s1_az_q) <<< 14)),
    .y_i     (-(XW'(s1_ay_q) <<< 14)),
    .p_i     (CW'(s1_mz_q) <<< 8),
    .q_i     (CW'(s1_my_q) <<< 8),
    .side_i  (r_side_in),
    .valid_o (r_valid),
    .len_o   (r_len),
    .z_o     (r_z),
    .p_o     (r_a),
    .q_o     (r_b),
    .side_o  (r_side)
  );

  // roll gain removal: multiply, then round
  logic g1_valid_q, g2_valid_q;
  logic signed [GW-1:0]  g1_a_q, g1_b_q;
  logic signed [GLW-1:0] g1_r_q;
  roll_side_t            g1_side_q, g2_side_q;
  logic signed [ZW-1:0]  g1_z_q, g2_z_q;
  logic signed [CW-1:0]  g2_tc_q, g2_pyc_q;
  logic signed [31:0]    g2_rc_q;
  logic signed [GW-1:0]  g1_a_rnd, g1_b_rnd;
  logic signed [GLW-1:0] g1_r_rnd;

  always_comb begin
    g1_a_rnd = (g1_a_q + (GW'(1) <<< (GainSh - 1))) >>> GainSh;
    g1_b_rnd = (g1_b_q + (GW'(1) <<< (GainSh - 1))) >>> GainSh;
    g1_r_rnd = (g1_r_q + (GLW'(1) <<< (GainSh - 1))) >>> GainSh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_valid_q <= 1'b0;
      g2_valid_q <= 1'b0;
    end else if (en) begin
      g1_valid_q <= r_valid;
      g2_valid_q <= g1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_a_q    <= r_a * GainInv;
      g1_b_q    <= r_b * GainInv;
      g1_r_q    <= $signed(r_len[31:0]) * GainInv;
      g1_z_q    <= r_z;
      g1_side_q <= r_side;
      g2_tc_q   <= CW'(g1_a_rnd);
      g2_pyc_q  <= CW'(g1_b_rnd);
      g2_rc_q   <= 32'(g1_r_rnd);
      g2_z_q    <= g1_z_q;
      g2_side_q <= g1_side_q;
    end
  end

  // pitch: vector (rc, ax), level (mx, tc)
  pitch_side_t          p_side_in, p_side;
  logic                 p_valid;
  logic signed [XW-1:0] p_len;
  logic signed [ZW-1:0] p_z;
  logic signed [CW-1:0] p_a, p_b;

  assign p_side_in = '{pyc: g2_pyc_q, zr: g2_z_q, deg: g2_side_q.deg};

  tcc_cordic #(.Iter(Iter), .SideW($bits(pitch_side_t))) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g2_valid_q),
    .x_i     (XW'(g2_rc_q)),
    .y_i     (XW'(g2_side_q.ax) <<< 14),
    .p_i     (CW'(g2_side_q.mx) <<< 8),
    .q_i     (g2_tc_q),
    .side_i  (p_side_in),
    .valid_o (p_valid),
    .len_o   (p_len),
    .z_o     (p_z),
    .p_o     (p_a),
    .q_o     (p_b),
    .side_o  (p_side)
  );

  // pitch gain removal, hard iron, soft iron
  logic h1_valid_q, h2_valid_q, h3_valid_q, h4_valid_q, h5_valid_q;
  logic signed [GW-1:0] h1_a_q, h1_a_rnd;
  pitch_side_t          h1_side_q, h2_side_q, h3_side_q, h4_side_q, h5_side_q;
  logic signed [ZW-1:0] h1_z_q, h2_z_q, h3_z_q, h4_z_q, h5_z_q;
  logic signed [CW-1:0] h2_pxc_q;
  logic signed [TW-1:0] h3_tx_q, h3_ty_q;
  logic signed [PW-1:0] h4_xx_q, h4_xy_q, h4_yx_q, h4_yy_q;
  logic signed [PW:0]   h4_cx_sum, h4_cy_sum;
  logic signed [XW-1:0] h5_cx_q, h5_cy_q;

  always_comb begin
    h1_a_rnd  = (h1_a_q + (GW'(1) <<< (GainSh - 1))) >>> GainSh;
    h4_cx_sum = ((PW+1)'(h4_xx_q) + (PW+1)'(h4_xy_q) + ((PW+1)'(1) <<< (SoftSh - 1)))
                >>> SoftSh;
    h4_cy_sum = ((PW+1)'(h4_yx_q) + (PW+1)'(h4_yy_q) + ((PW+1)'(1) <<< (SoftSh - 1)))
                >>> SoftSh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_valid_q <= 1'b0;
      h2_valid_q <= 1'b0;
      h3_valid_q <= 1'b0;
      h4_valid_q <= 1'b0;
      h5_valid_q <= 1'b0;
    end else if (en) begin
      h1_valid_q <= p_valid;
      h2_valid_q <= h1_valid_q;
      h3_valid_q <= h2_valid_q;
      h4_valid_q <= h3_valid_q;
      h5_valid_q <= h4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_a_q    <= p_a * GainInv;
      h1_z_q    <= p_z;
      h1_side_q <= p_side;
      h2_pxc_q  <= CW'(h1_a_rnd);
      h2_z_q    <= h1_z_q;
      h2_side_q <= h1_side_q;
      h3_tx_q   <= TW'(h2_pxc_q) - (TW'(hard_x_q) <<< 8);
      h3_ty_q   <= TW'(h2_side_q.pyc) - (TW'(hard_y_q) <<< 8);
      h3_z_q    <= h2_z_q;
      h3_side_q <= h2_side_q;
      h4_xx_q   <= soft_xx_q * h3_tx_q;
      h4_xy_q   <= soft_xy_q * h3_ty_q;
      h4_yx_q   <= soft_yx_q * h3_tx_q;
      h4_yy_q   <= soft_yy_q * h3_ty_q;
      h4_z_q    <= h3_z_q;
      h4_side_q <= h3_side_q;
      h5_cx_q   <= XW'(h4_cx_sum);
      h5_cy_q   <= XW'(h4_cy_sum);
      h5_z_q    <= h4_z_q;
      h5_side_q <= h4_side_q;
    end
  end

  // heading
  yaw_side_t            y_side_in, y_side;
  logic                 y_valid;
  logic signed [XW-1:0] y_len;
  logic signed [ZW-1:0] y_z;
  logic signed [CW-1:0] y_a, y_b;

  assign y_side_in = '{zr: h5_side_q.zr, zp: h5_z_q, deg: h5_side_q.deg};

  tcc_cordic #(.Iter(Iter), .SideW($bits(yaw_side_t))) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h5_valid_q),
    .x_i     (h5_cx_q),
    .y_i     (h5_cy_q),
    .p_i     ('0),
    .q_i     ('0),
    .side_i  (y_side_in),
    .valid_o (y_valid),
    .len_o   (y_len),
    .z_o     (y_z),
    .p_o     (y_a),
    .q_o     (y_b),
    .side_o  (y_side)
  );

  // final scaling; pitch length, pitch q and the heading unit's length and
  // companions are not needed
  logic               f_valid_q, f_deg_q;
  logic [43:0]        f_data_q;
  logic signed [15:0] f_roll, f_pitch, f_yaw;
  logic               y_unused;

  assign y_unused = ^{y_len, y_a, y_b, p_len, p_b};

  always_comb begin
    f_roll  = ang_out((ZW+1)'(y_side.zr), LimFull);
    f_pitch = ang_out((ZW+1)'(y_side.zp), LimHalf);
    f_yaw   = ang_out(-(ZW+1)'(y_z), LimFull);
    if (y_side.deg) begin
      f_roll  = '0;
      f_pitch = '0;
      f_yaw   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= y_valid & (y_unused | ~y_unused);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_data_q <= {f_yaw[14:0], f_pitch[13:0], f_roll[14:0]};
      f_deg_q  <= y_side.deg;
    end
  end

  // output register with one-word skid
  logic [43:0] out_data_q, skid_data_q;
  logic        out_deg_q, skid_deg_q;
  logic        take;

  assign take = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (f_valid_q) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
        out_deg_q  <= skid_deg_q;
      end
    end else if (f_valid_q) begin
      if (out_valid_q && !take) begin
        skid_data_q <= f_data_q;
        skid_deg_q  <= f_deg_q;
      end else begin
        out_data_q <= f_data_q;
        out_deg_q  <= f_deg_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_data_q};
  assign m_axis_tuser  = out_deg_q;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid filled without an output stall");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("degenerate word carries nonzero angles");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[28:15]) <= 14'sd5760 &&
                       $signed(m_axis_tdata[28:15]) >= -14'sd5760))
    else $error("pitch out of range");

endmodule
